@@ hdl/cws_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Context window stacker package
// Shared word type, defaults, register indexes and the sequencer step record.
// ----------------------------------------------------------------------------
package cws_pkg;

	// One feature word, signed Q16.16, copied bit for bit.
	typedef logic signed [31:0] word_t;

	// Lane count of the ports.
	localparam int unsigned LANES = 8;

	// Defaults for the top-level parameters.
	localparam int unsigned DEF_MAX_FEATURES = 8;
	localparam int unsigned DEF_MAX_LEFT     = 3;
	localparam int unsigned DEF_MAX_RIGHT    = 3;
	localparam int unsigned DEF_RING_EPOCHS  = 8;

	// Configuration register widths and reset values.
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 4;
	localparam logic [1:0] LEFT_RST  = 2'd1;
	localparam logic [1:0] RIGHT_RST = 2'd1;
	localparam logic [3:0] LANES_RST = 4'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEFT  = 2'd0,
		CFG_RIGHT = 2'd1,
		CFG_LANES = 2'd2
	} cfg_reg_t;

	// Back distance of a source epoch never exceeds left plus right.
	localparam int unsigned DIST_W = 3;
	localparam logic [3:0] SEEN_MAX = 4'd15;

	// One block request from the sequencer to the output stage.
	typedef struct packed {
		logic              valid;
		logic [DIST_W-1:0] back_dist;
		logic [3:0]        lanes;
		logic              row_end;
		logic              record_end;
	} step_t;

endpackage

@@ hdl/cws_epoch_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch channel
// Carries one epoch of feature words and the last-epoch flag per word.
// ----------------------------------------------------------------------------
interface cws_epoch_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] feature_0;
	logic signed [31:0] feature_1;
	logic signed [31:0] feature_2;
	logic signed [31:0] feature_3;
	logic signed [31:0] feature_4;
	logic signed [31:0] feature_5;
	logic signed [31:0] feature_6;
	logic signed [31:0] feature_7;
	logic               final_epoch;

	modport source (
		output valid, feature_0, feature_1, feature_2, feature_3,
		feature_4, feature_5, feature_6, feature_7, final_epoch,
		input  ready
	);
	modport sink (
		input  valid, feature_0, feature_1, feature_2, feature_3,
		feature_4, feature_5, feature_6, feature_7, final_epoch,
		output ready
	);
endinterface

@@ hdl/cws_block_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block channel
// Carries one stacked block of a context row per word.
// ----------------------------------------------------------------------------
interface cws_block_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] block_0;
	logic signed [31:0] block_1;
	logic signed [31:0] block_2;
	logic signed [31:0] block_3;
	logic signed [31:0] block_4;
	logic signed [31:0] block_5;
	logic signed [31:0] block_6;
	logic signed [31:0] block_7;
	logic               row_end;
	logic               record_end;

	modport source (
		output valid, block_0, block_1, block_2, block_3,
		block_4, block_5, block_6, block_7, row_end, record_end,
		input  ready
	);
	modport sink (
		input  valid, block_0, block_1, block_2, block_3,
		block_4, block_5, block_6, block_7, row_end, record_end,
		output ready
	);
endinterface

@@ hdl/cws_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch cell
// Holds one epoch and passes it to the next cell when a new epoch enters.
// ----------------------------------------------------------------------------
module cws_cell #(
	parameter int unsigned MAX_FEATURES = cws_pkg::DEF_MAX_FEATURES
) (
	input  logic           clk,
	input  logic           shift,
	input  cws_pkg::word_t d [MAX_FEATURES],
	output cws_pkg::word_t q [MAX_FEATURES]
);
	import cws_pkg::*;

	word_t epoch_q [MAX_FEATURES];

	always_ff @(posedge clk) begin
		if (shift) begin
			for (int j = 0; j < int'(MAX_FEATURES); j++) begin
				epoch_q[j] <= d[j];
			end
		end
	end

	assign q = epoch_q;

endmodule

@@ hdl/cws_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row sequencer
// Counts epochs of the record and walks the rows and blocks due per epoch.
// ----------------------------------------------------------------------------
module cws_ctrl #(
	parameter int unsigned MAX_LEFT  = cws_pkg::DEF_MAX_LEFT,
	parameter int unsigned MAX_RIGHT = cws_pkg::DEF_MAX_RIGHT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           final_epoch,
	input  logic [1:0]     left_cfg,
	input  logic [1:0]     right_cfg,
	input  logic [3:0]     lanes,
	input  logic           advance,
	output logic           busy,
	output cws_pkg::step_t step
);
	import cws_pkg::*;

	logic       busy_q;
	logic [3:0] seen_q;
	logic [1:0] left_q, right_q, b_q, blo_q;
	logic [3:0] lanes_q, n_q;
	logic       final_q;
	logic [2:0] o_q;

	logic [1:0] left_sat, right_sat, b_hi, b_lo;
	logic [2:0] span;
	logic signed [4:0] dist_raw;
	logic [3:0] dist_clamp;

	assign left_sat  = (left_cfg > 2'(MAX_LEFT)) ? 2'(MAX_LEFT) : left_cfg;
	assign right_sat = (right_cfg > 2'(MAX_RIGHT)) ? 2'(MAX_RIGHT) : right_cfg;

	// On the last epoch every row still pending is flushed, down to the
	// row centered on the last epoch itself.
	always_comb begin
		if (final_epoch) begin
			b_lo = 2'd0;
			b_hi = ({2'b0, right_sat} < seen_q) ? right_sat : seen_q[1:0];
		end else begin
			b_lo = right_sat;
			b_hi = right_sat;
		end
	end

	assign span = {1'b0, left_q} + {1'b0, right_q};

	// Source back distance, clamped to the first epoch of the record and
	// to the newest one.
	always_comb begin
		dist_raw = $signed({3'b0, b_q}) + $signed({3'b0, left_q}) - $signed({2'b0, o_q});
		if (dist_raw < 0) begin
			dist_clamp = 4'd0;
		end else if (dist_raw[3:0] > n_q) begin
			dist_clamp = n_q;
		end else begin
			dist_clamp = dist_raw[3:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			seen_q <= 4'd0;
		end else if (start) begin
			busy_q <= final_epoch || (seen_q >= {2'b0, right_sat});
			if (final_epoch) begin
				seen_q <= 4'd0;
			end else if (seen_q != SEEN_MAX) begin
				seen_q <= seen_q + 4'd1;
			end
		end else if (busy_q && advance) begin
			if (o_q == span && b_q == blo_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			left_q  <= left_sat;
			right_q <= right_sat;
			lanes_q <= lanes;
			n_q     <= seen_q;
			final_q <= final_epoch;
			b_q     <= b_hi;
			blo_q   <= b_lo;
			o_q     <= 3'd0;
		end else if (busy_q && advance) begin
			if (o_q == span) begin
				if (b_q != blo_q) begin
					b_q <= b_q - 2'd1;
					o_q <= 3'd0;
				end
			end else begin
				o_q <= o_q + 3'd1;
			end
		end
	end

	assign busy            = busy_q;
	assign step.valid      = busy_q;
	assign step.back_dist  = dist_clamp[DIST_W-1:0];
	assign step.lanes      = lanes_q;
	assign step.row_end    = (o_q == span);
	assign step.record_end = final_q && (b_q == 2'd0) && (o_q == span);

endmodule

@@ hdl/context_window_stacker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Context window stacker
// Splices each epoch with its neighbors into rows of blocks, edges repeated.
// ----------------------------------------------------------------------------
// An accepted epoch loads the row sequencer; each block it walks then goes
// through the output register. The sequencer hands one block per cycle to
// that register while it is empty or being drained (up to (left+right+1)
// blocks per row, up to right+1 rows on last epoch); no epoch enters meanwhile.
// Reset (arst_n low) clears the epoch count, the sequencer and the output
// valid flag and restores the register defaults; epoch cells hold no reset.
// ----------------------------------------------------------------------------
module context_window_stacker #(
	parameter int unsigned MAX_FEATURES = cws_pkg::DEF_MAX_FEATURES,
	parameter int unsigned MAX_LEFT     = cws_pkg::DEF_MAX_LEFT,
	parameter int unsigned MAX_RIGHT    = cws_pkg::DEF_MAX_RIGHT,
	parameter int unsigned RING_EPOCHS  = cws_pkg::DEF_RING_EPOCHS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [cws_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cws_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	cws_epoch_if.sink                        epoch,
	cws_block_if.source                      stack
);
	import cws_pkg::*;

	localparam int unsigned IDX_W = (RING_EPOCHS > 1) ? $clog2(RING_EPOCHS) : 1;
	// Distances reach at most six, so three subtractions fold them into the ring.
	localparam int unsigned FOLD_STEPS = 3;

	// Configuration registers, to write only while the block is idle; unchecked.
	logic [1:0] left_q, right_q;
	logic [3:0] lanes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= LEFT_RST;
			right_q <= RIGHT_RST;
			lanes_q <= LANES_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_LEFT:  left_q  <= cfg_wdata[1:0];
				CFG_RIGHT: right_q <= cfg_wdata[1:0];
				CFG_LANES: lanes_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Lane counts above the stored width behave as the stored width.
	logic [3:0] lanes_sat;
	assign lanes_sat = (lanes_q > 4'(MAX_FEATURES)) ? 4'(MAX_FEATURES) : lanes_q;

	// Input handshake: a new epoch is taken only while the row sequencer is idle.
	logic busy, start, advance;
	step_t step;

	assign epoch.ready = !busy;
	assign start       = epoch.valid && epoch.ready;

	// Chain of epoch cells: cell 0 holds the newest epoch, cell k the epoch
	// accepted k words earlier. Every accepted epoch shifts the whole chain.
	word_t feat_in [LANES];
	assign feat_in[0] = epoch.feature_0;
	assign feat_in[1] = epoch.feature_1;
	assign feat_in[2] = epoch.feature_2;
	assign feat_in[3] = epoch.feature_3;
	assign feat_in[4] = epoch.feature_4;
	assign feat_in[5] = epoch.feature_5;
	assign feat_in[6] = epoch.feature_6;
	assign feat_in[7] = epoch.feature_7;

	word_t head_d  [MAX_FEATURES];
	word_t chain_q [RING_EPOCHS][MAX_FEATURES];

	always_comb begin
		for (int j = 0; j < int'(MAX_FEATURES); j++) begin
			head_d[j] = feat_in[j];
		end
	end

	for (genvar k = 0; k < int'(RING_EPOCHS); k++) begin : g_cell
		if (k == 0) begin : g_head
			cws_cell #(.MAX_FEATURES(MAX_FEATURES)) u_cell (
				.clk  (clk),
				.shift(start),
				.d    (head_d),
				.q    (chain_q[k])
			);
		end else begin : g_body
			cws_cell #(.MAX_FEATURES(MAX_FEATURES)) u_cell (
				.clk  (clk),
				.shift(start),
				.d    (chain_q[k-1]),
				.q    (chain_q[k])
			);
		end
	end

	cws_ctrl #(
		.MAX_LEFT (MAX_LEFT),
		.MAX_RIGHT(MAX_RIGHT)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.final_epoch(epoch.final_epoch),
		.left_cfg   (left_q),
		.right_cfg  (right_q),
		.lanes      (lanes_sat),
		.advance    (advance),
		.busy       (busy),
		.step       (step)
	);

	// A short chain behaves like a ring that wraps: a back distance beyond
	// the chain lands on the cell it aliases to.
	logic [3:0] fold;
	logic [IDX_W-1:0] cell_idx;

	always_comb begin
		fold = {1'b0, step.back_dist};
		for (int i = 0; i < int'(FOLD_STEPS); i++) begin
			if (fold >= 4'(RING_EPOCHS)) begin
				fold = fold - 4'(RING_EPOCHS);
			end
		end
		cell_idx = fold[IDX_W-1:0];
	end

	// Output register: loads a block whenever it is empty or being drained,
	// so the sequencer keeps going while the sink takes the previous word.
	logic  valid_q;
	word_t block_q [LANES];
	logic  row_end_q, record_end_q;

	assign advance = step.valid && (!valid_q || stack.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (stack.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int j = 0; j < int'(LANES); j++) begin
				// Lanes past the configured count, and past the stored
				// width, read as zero.
				if (j < int'(MAX_FEATURES) && 4'(j) < step.lanes) begin
					block_q[j] <= chain_q[cell_idx][j];
				end else begin
					block_q[j] <= '0;
				end
			end
			row_end_q    <= step.row_end;
			record_end_q <= step.record_end;
		end
	end

	assign stack.valid      = valid_q;
	assign stack.block_0    = block_q[0];
	assign stack.block_1    = block_q[1];
	assign stack.block_2    = block_q[2];
	assign stack.block_3    = block_q[3];
	assign stack.block_4    = block_q[4];
	assign stack.block_5    = block_q[5];
	assign stack.block_6    = block_q[6];
	assign stack.block_7    = block_q[7];
	assign stack.row_end    = row_end_q;
	assign stack.record_end = record_end_q;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Context window stacker testbench
// Feeds records of epochs through the stacker under several register settings
// and idle patterns. A behavioral copy of the splicer predicts every block
// word, and a monitor checks each received block against the oldest one.
// ----------------------------------------------------------------------------
module testbench;

	import cws_pkg::*;

	// Limits of the block as built with its default parameters.
	localparam int MAX_LANES = DEF_MAX_FEATURES;
	localparam int LEFT_CAP  = DEF_MAX_LEFT;
	localparam int RIGHT_CAP = DEF_MAX_RIGHT;
	localparam int RING      = DEF_RING_EPOCHS;

	// Cycles to let pass once nothing is expected, enough for a full flush of
	// the longest row set (four rows of seven blocks plus start-up).
	localparam int SETTLE = 40;
	// Cycles with no accepted word or register write before a hang is declared.
	localparam int QUIET_LIMIT = 2000;
	// Number of register settings the run goes through.
	localparam int PHASES = 10;
	// Random epochs in each phase.
	localparam int EPOCHS_PER_PHASE = 31;

	// One epoch as the sender presents it.
	typedef struct packed {
		logic [LANES-1:0][31:0] lane;
		logic                   last;
	} epoch_word_t;

	// One block of a context row as the receiver sees it.
	typedef struct packed {
		logic [LANES-1:0][31:0] lane;
		logic                   row_end;
		logic                   record_end;
	} block_word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	cws_epoch_if epoch_ch ();
	cws_block_if stack_ch ();

	context_window_stacker i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.epoch     (epoch_ch),
		.stack     (stack_ch)
	);

	// Epochs waiting to be offered and blocks waiting to be received.
	epoch_word_t epoch_backlog[$];
	block_word_t expected_blocks[$];

	// Our own view of the register file, updated as each write lands.
	logic [1:0] cfg_left;
	logic [1:0] cfg_right;
	logic [3:0] cfg_lanes;

	// Splicer state: the epoch ring, the next slot and the epoch count.
	logic [LANES-1:0][31:0] epoch_ring [RING];
	int write_slot;
	int epochs_seen;

	// Idle percentages of the current phase.
	int send_idle_pct;
	int stall_pct;

	// Set when the epoch on the channel was taken at the last rising edge.
	bit epoch_taken;
	int failures;
	int quiet_cycles;
	// Epochs still to come in the record under construction.
	int record_remaining;

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Prediction. Store the epoch, then emit each ready row as a run of blocks
	// from t-left through t+right, with source distances clamped to the record
	// so that both edges repeat the nearest real epoch.
	// ------------------------------------------------------------------------
	task automatic splice_epoch(input epoch_word_t ep);
		int lft;
		int rgt;
		int lanes;
		int n;
		int ws;
		int b_lo;
		int b_hi;
		int span;
		int b;
		int o;
		int s;
		int slot;
		int j;
		block_word_t blk;
		lft = (int'(cfg_left) > LEFT_CAP) ? LEFT_CAP : int'(cfg_left);
		rgt = (int'(cfg_right) > RIGHT_CAP) ? RIGHT_CAP : int'(cfg_right);
		lanes = (int'(cfg_lanes) > MAX_LANES) ? MAX_LANES : int'(cfg_lanes);
		n = epochs_seen;
		ws = write_slot;
		epoch_ring[ws] = ep.lane;
		// The row centre sits b epochs behind the one just stored. A normal
		// epoch releases the row right epochs back; the last one releases
		// every row still pending, down to itself.
		if (ep.last) begin
			b_lo = 0;
			b_hi = (rgt < n) ? rgt : n;
		end else begin
			b_lo = rgt;
			b_hi = rgt;
		end
		if (ep.last || n >= rgt) begin
			span = lft + rgt;
			for (b = b_hi; b >= b_lo; b--) begin
				for (o = 0; o <= span; o++) begin
					s = b + lft - o;
					if (s < 0)
						s = 0;
					if (s > n)
						s = n;
					slot = (ws + RING - s) % RING;
					for (j = 0; j < LANES; j++)
						blk.lane[j] = (j < lanes) ? epoch_ring[slot][j] : 32'd0;
					blk.row_end = (o == span);
					blk.record_end = ep.last && (b == 0) && (o == span);
					expected_blocks.push_back(blk);
				end
			end
		end
		// A last epoch starts a fresh record; otherwise the count saturates.
		if (ep.last) begin
			write_slot = 0;
			epochs_seen = 0;
		end else begin
			write_slot = (ws + 1) % RING;
			epochs_seen = (n < int'(SEEN_MAX)) ? n + 1 : int'(SEEN_MAX);
		end
	endtask

	// Feature words lean on the extremes of Q16.16 so that sign and every bit
	// are seen both ways, with plain random words in between.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: pick_word = 32'h8000_0000;
			1: pick_word = 32'h7FFF_FFFF;
			2: pick_word = 32'h0000_0000;
			3: pick_word = 32'hFFFF_FFFF;
			default: pick_word = $urandom();
		endcase
	endfunction

	// Records are mostly short, sometimes long enough to saturate the count.
	function automatic int pick_record_length();
		if ($urandom_range(0, 9) == 0)
			pick_record_length = $urandom_range(12, 20);
		else
			pick_record_length = $urandom_range(1, 7);
	endfunction

	// Append random epochs, opening new records as needed. A phase may end
	// inside a record, so the next setting applies to the rest of it.
	task automatic queue_epochs(input int count);
		epoch_word_t ep;
		int i;
		int j;
		@(posedge clk);
		for (i = 0; i < count; i++) begin
			if (record_remaining == 0)
				record_remaining = pick_record_length();
			for (j = 0; j < LANES; j++)
				ep.lane[j] = pick_word();
			ep.last = (record_remaining == 1);
			record_remaining--;
			epoch_backlog.push_back(ep);
		end
	endtask

	// A directed epoch with every lane set from one word pair.
	task automatic queue_pattern(input logic [31:0] even_word, input logic [31:0] odd_word,
		input logic last);
		epoch_word_t ep;
		int j;
		for (j = 0; j < LANES; j++)
			ep.lane[j] = j[0] ? odd_word : even_word;
		ep.last = last;
		epoch_backlog.push_back(ep);
	endtask

	// Hold off until nothing is queued, on the channel or still expected,
	// then give the block time to finish any epoch that yields no blocks.
	task automatic wait_for_drain();
		while (epoch_backlog.size() != 0 || epoch_ch.valid || expected_blocks.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// One register write; our copy follows once the write edge has passed.
	task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_LEFT:  cfg_left = data[1:0];
			CFG_RIGHT: cfg_right = data[1:0];
			CFG_LANES: cfg_lanes = data;
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Sender. At each falling edge, if the channel is free or its word was just
	// taken, either offer the next epoch or go idle. valid gets one assignment
	// per edge, so back-to-back words keep it high without a glitch.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin : epoch_driver
		epoch_word_t nxt;
		if (arst_n && (!epoch_ch.valid || epoch_taken)) begin
			epoch_taken = 1'b0;
			if (epoch_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = epoch_backlog.pop_front();
				epoch_ch.valid       <= 1'b1;
				epoch_ch.feature_0   <= nxt.lane[0];
				epoch_ch.feature_1   <= nxt.lane[1];
				epoch_ch.feature_2   <= nxt.lane[2];
				epoch_ch.feature_3   <= nxt.lane[3];
				epoch_ch.feature_4   <= nxt.lane[4];
				epoch_ch.feature_5   <= nxt.lane[5];
				epoch_ch.feature_6   <= nxt.lane[6];
				epoch_ch.feature_7   <= nxt.lane[7];
				epoch_ch.final_epoch <= nxt.last;
			end else begin
				epoch_ch.valid <= 1'b0;
			end
		end
	end

	// Each accepted epoch is predicted from what was on the wires.
	always @(posedge clk) begin : epoch_capture
		epoch_word_t seen;
		if (arst_n && epoch_ch.valid && epoch_ch.ready) begin
			seen.lane[0] = epoch_ch.feature_0;
			seen.lane[1] = epoch_ch.feature_1;
			seen.lane[2] = epoch_ch.feature_2;
			seen.lane[3] = epoch_ch.feature_3;
			seen.lane[4] = epoch_ch.feature_4;
			seen.lane[5] = epoch_ch.feature_5;
			seen.lane[6] = epoch_ch.feature_6;
			seen.lane[7] = epoch_ch.feature_7;
			seen.last = epoch_ch.final_epoch;
			splice_epoch(seen);
			epoch_taken = 1'b1;
		end
	end

	// Receiver back-pressure, redrawn every cycle.
	always @(negedge clk) begin
		stack_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// ------------------------------------------------------------------------
	// Monitor. Every received block must match the oldest expectation in
	// every lane and in both end flags.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : block_monitor
		block_word_t got;
		block_word_t want;
		int j;
		if (arst_n && stack_ch.valid && stack_ch.ready) begin
			got.lane[0] = stack_ch.block_0;
			got.lane[1] = stack_ch.block_1;
			got.lane[2] = stack_ch.block_2;
			got.lane[3] = stack_ch.block_3;
			got.lane[4] = stack_ch.block_4;
			got.lane[5] = stack_ch.block_5;
			got.lane[6] = stack_ch.block_6;
			got.lane[7] = stack_ch.block_7;
			got.row_end = stack_ch.row_end;
			got.record_end = stack_ch.record_end;
			if (expected_blocks.size() == 0) begin
				$error("block word received with none expected: %h", got);
				failures++;
			end else begin
				want = expected_blocks.pop_front();
				for (j = 0; j < LANES; j++) begin
					if (got.lane[j] !== want.lane[j]) begin
						$error("block_%0d: expected %h, actual %h", j, want.lane[j],
							got.lane[j]);
						failures++;
					end
				end
				if (got.row_end !== want.row_end) begin
					$error("row_end: expected %b, actual %b", want.row_end, got.row_end);
					failures++;
				end
				if (got.record_end !== want.record_end) begin
					$error("record_end: expected %b, actual %b", want.record_end,
						got.record_end);
					failures++;
				end
			end
		end
	end

	// Watchdog: any accepted word or register write counts as progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((epoch_ch.valid && epoch_ch.ready) || (stack_ch.valid && stack_ch.ready)
				|| cfg_wr_en)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sequence of the run: reset, a directed set of records under the reset
	// settings, then one phase per register setting, each with its own idle
	// pattern. Registers change only after the block has fully drained.
	// ------------------------------------------------------------------------
	initial begin : run_sequence
		int p;
		int half;
		logic [CFG_DATA_W-1:0] left_w;
		logic [CFG_DATA_W-1:0] right_w;
		logic [CFG_DATA_W-1:0] lanes_w;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_LEFT;
		cfg_wdata = '0;
		epoch_ch.valid = 1'b0;
		epoch_ch.feature_0 = '0;
		epoch_ch.feature_1 = '0;
		epoch_ch.feature_2 = '0;
		epoch_ch.feature_3 = '0;
		epoch_ch.feature_4 = '0;
		epoch_ch.feature_5 = '0;
		epoch_ch.feature_6 = '0;
		epoch_ch.feature_7 = '0;
		epoch_ch.final_epoch = 1'b0;
		stack_ch.ready = 1'b0;
		cfg_left = LEFT_RST;
		cfg_right = RIGHT_RST;
		cfg_lanes = LANES_RST;
		write_slot = 0;
		epochs_seen = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		epoch_taken = 1'b0;
		failures = 0;
		quiet_cycles = 0;
		record_remaining = 0;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Directed records under the reset settings. A lone final epoch is
		// both edges of its only row; the two-epoch record ends before the
		// right context fills, so all its rows come out on the final epoch.
		@(posedge clk);
		queue_pattern(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		queue_pattern(32'h8000_0000, 32'h8000_0000, 1'b1);
		queue_pattern(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
		queue_pattern(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
		queue_pattern(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		queue_pattern(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
		queue_pattern(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
		queue_pattern(32'h0001_0000, 32'hFFFF_0000, 1'b0);
		queue_pattern(32'h0000_0001, 32'h8000_0001, 1'b0);
		queue_pattern(32'h1234_5678, 32'hEDCB_A987, 1'b0);
		queue_pattern(32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0);
		queue_pattern(32'h7FFF_0000, 32'h0000_FFFF, 1'b1);
		wait_for_drain();

		for (p = 0; p < PHASES; p++) begin
			// Idle patterns rotate: none, sender gaps, receiver stalls, both.
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 54; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 54; end
				default: begin send_idle_pct = 11; stall_pct = 11; end
			endcase

			// Settings cover no context at all, the widest window, a single lane,
			// no lanes, lane counts past the port width, and register data with
			// the unused upper bits set.
			case (p)
				0: begin left_w = 4'd0; right_w = 4'd0; lanes_w = 4'd8;  end
				1: begin left_w = 4'd3; right_w = 4'd3; lanes_w = 4'd1;  end
				2: begin left_w = 4'd2; right_w = 4'd1; lanes_w = 4'd0;  end
				3: begin left_w = 4'hF; right_w = 4'hC; lanes_w = 4'd15; end
				4: begin left_w = 4'd1; right_w = 4'd3; lanes_w = 4'd5;  end
				5: begin left_w = 4'd3; right_w = 4'd0; lanes_w = 4'd9;  end
				6: begin left_w = 4'd0; right_w = 4'hB; lanes_w = 4'd8;  end
				9: begin left_w = 4'd3; right_w = 4'd3; lanes_w = 4'd8;  end
				default: begin
					left_w = 4'($urandom_range(0, 15));
					right_w = 4'($urandom_range(0, 15));
					lanes_w = 4'($urandom_range(0, 15));
				end
			endcase
			write_register(CFG_LEFT, left_w);
			write_register(CFG_RIGHT, right_w);
			write_register(CFG_LANES, lanes_w);

			// In every third phase the sender stops halfway and waits until all
			// outstanding blocks have been received before going on.
			if (p % 3 == 0) begin
				half = EPOCHS_PER_PHASE / 2;
				queue_epochs(half);
				wait_for_drain();
				queue_epochs(EPOCHS_PER_PHASE - half);
			end else begin
				queue_epochs(EPOCHS_PER_PHASE);
			end

			// Close the last record so that its rows are flushed.
			if (p == PHASES - 1 && record_remaining != 0) begin
				record_remaining = 1;
				queue_epochs(1);
			end
			wait_for_drain();
		end

		if (failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
